// ----- src/stpm_pkg.sv -----
package stpm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = SAMPLE_W - 1;
    localparam int GAIN_W     = 23;
    localparam int CFG_W      = 23;
    localparam int SUM_W      = 60;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int MAX_BLOCK  = 16384;
    localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int TRIM_SHIFT = 16;
    localparam int RND_W      = PROD_W + 1 - TRIM_SHIFT;

    localparam logic [MAG_W-1:0]  MAG_MAX    = '1;
    localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] BYPASS_TOL = GAIN_W'(65);
    localparam logic [PROD_W:0]   ROUND_BIAS = (PROD_W + 1)'(1) << (TRIM_SHIFT - 1);

    typedef enum logic [0:0] {
        CFG_TRIM_GAIN     = 1'b0,
        CFG_RIGHT_PRESENT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       block_end;
    } sample_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] trimmed_left;
        logic signed [SAMPLE_W-1:0] trimmed_right;
        logic                       meter_valid;
        logic [MAG_W-1:0]           peak_left;
        logic [MAG_W-1:0]           peak_right;
        logic [MAG_W-1:0]           rms_left;
        logic [MAG_W-1:0]           rms_right;
    } meter_out_t;

    // Command bundle from the top-level sequencer to each channel.
    typedef struct packed {
        logic start;
        logic ack;
        logic bypass;
        logic meter;
        logic last;
    } chan_cmd_t;

endpackage

// ----- src/stpm_mul.sv -----
module stpm_mul
    import stpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [SAMPLE_W-1:0] mcand,
    input  logic [GAIN_W-1:0]   mplier,
    output logic [PROD_W-1:0]   prod,
    output logic                done
);

    localparam int CNT_BITS = $clog2(GAIN_W + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [SAMPLE_W-1:0] mcand_reg, mcand_next;
    logic [SAMPLE_W:0]   upper;

    // Shift-add, one multiplier bit per cycle, LSB first. The multiplier sits
    // in the low half of the accumulator and shifts out as the product grows.
    always_comb
    begin
        upper      = {1'b0, acc_reg[PROD_W-1:GAIN_W]}
                   + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            acc_next   = {SAMPLE_W'(0), mplier};
            mcand_next = mcand;
            cnt_next   = CNT_BITS'(GAIN_W);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = {upper, acc_reg[GAIN_W-1:1]};
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign prod = acc_reg;
    assign done = (cnt_reg == '0);

endmodule

// ----- src/stpm_div.sv -----
module stpm_div
    import stpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_BITS = $clog2(SUM_W + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      diff;
    logic                ge;

    // Restoring division: the dividend shifts out of the top of quo_reg
    // while quotient bits shift in at the bottom.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_BITS'(SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

// ----- src/stpm_sqrt.sv -----
module stpm_sqrt
    import stpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [SUM_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int CNT_BITS = $clog2(ROOT_W + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                ge;

    // Digit-by-digit floor square root, two radicand bits per cycle.
    // The partial remainder never exceeds twice the partial root.
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SUM_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_BITS'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            rad_next  = {rad_reg[SUM_W-3:0], 2'b00};
            rem_next  = ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = (cnt_reg == '0);

endmodule

// ----- src/stpm_chan.sv -----
module stpm_chan
    import stpm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  chan_cmd_t                  cmd,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]          gain,
    input  logic [CNT_W-1:0]           count,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] trimmed,
    output logic [MAG_W-1:0]           peak,
    output logic [MAG_W-1:0]           rms
);

    typedef enum logic [7:0] {
        C_IDLE = 8'b0000_0001,
        C_TRIM = 8'b0000_0010,
        C_SQL  = 8'b0000_0100,
        C_SQ   = 8'b0000_1000,
        C_ACC  = 8'b0001_0000,
        C_DIV  = 8'b0010_0000,
        C_SQRT = 8'b0100_0000,
        C_DONE = 8'b1000_0000
    } chan_state_t;

    chan_state_t state_reg, state_next;

    logic [MAG_W-1:0]           peak_acc_reg, peak_acc_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] trim_reg, trim_next;
    logic [MAG_W-1:0]           peak_out_reg, peak_out_next;
    logic [MAG_W-1:0]           rms_reg, rms_next;
    logic                       neg_reg, neg_next;
    logic                       last_reg, last_next;
    logic                       meter_reg, meter_next;
    logic                       div_zero_reg, div_zero_next;

    logic                mul_load;
    logic [SAMPLE_W-1:0] mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                mul_done;
    logic                div_load;
    logic [SUM_W-1:0]    quotient;
    logic                div_done;
    logic                sqrt_load;
    logic [ROOT_W-1:0]   root;
    logic                sqrt_done;

    logic [SAMPLE_W-1:0]        mag_in;
    logic [PROD_W:0]            round_sum;
    logic [RND_W-1:0]           rnd;
    logic [SAMPLE_W-1:0]        rc;
    logic signed [SAMPLE_W-1:0] trim_val;
    logic [SAMPLE_W-1:0]        abs_t;
    logic [MAG_W-1:0]           mm;
    logic [SUM_W:0]             sum_wide;
    logic [MAG_W-1:0]           peak_upd;
    logic [SUM_W-1:0]           sum_upd;
    logic [MAG_W-1:0]           root_clip;

    stpm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mul_load),
        .mcand  (mul_a),
        .mplier (mul_b),
        .prod   (mul_prod),
        .done   (mul_done)
    );

    stpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (sum_upd),
        .divisor  (count),
        .quotient (quotient),
        .done     (div_done)
    );

    stpm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (sqrt_load),
        .radicand (quotient),
        .root     (root),
        .done     (sqrt_done)
    );

    // Datapath terms
    always_comb
    begin
        mag_in    = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

        // Round half away from zero on the magnitude, then saturate. The
        // negative side may reach one step beyond the positive full scale.
        round_sum = {1'b0, mul_prod} + ROUND_BIAS;
        rnd       = round_sum[PROD_W:TRIM_SHIFT];
        if (neg_reg)
        begin
            rc = (rnd > RND_W'(MAG_MAX) + RND_W'(1))
               ? SAMPLE_W'(MAG_MAX) + SAMPLE_W'(1) : rnd[SAMPLE_W-1:0];
        end
        else
        begin
            rc = (rnd > RND_W'(MAG_MAX)) ? SAMPLE_W'(MAG_MAX) : rnd[SAMPLE_W-1:0];
        end
        trim_val  = neg_reg ? -rc : rc;

        // The most negative sample meters as full scale.
        abs_t     = trim_reg[SAMPLE_W-1] ? SAMPLE_W'(-trim_reg) : SAMPLE_W'(trim_reg);
        mm        = (abs_t > SAMPLE_W'(MAG_MAX)) ? MAG_MAX : abs_t[MAG_W-1:0];

        sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(mul_prod[2*MAG_W-1:0]);
        if (meter_reg)
        begin
            peak_upd = (mm > peak_acc_reg) ? mm : peak_acc_reg;
            sum_upd  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
        else
        begin
            peak_upd = peak_acc_reg;
            sum_upd  = sum_reg;
        end

        root_clip = (root > ROOT_W'(MAG_MAX)) ? MAG_MAX : root[MAG_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        peak_acc_next = peak_acc_reg;
        sum_next      = sum_reg;
        trim_next     = trim_reg;
        peak_out_next = peak_out_reg;
        rms_next      = rms_reg;
        neg_next      = neg_reg;
        last_next     = last_reg;
        meter_next    = meter_reg;
        div_zero_next = div_zero_reg;
        mul_load      = 1'b0;
        mul_a         = mag_in;
        mul_b         = gain;
        div_load      = 1'b0;
        sqrt_load     = 1'b0;

        unique case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    last_next  = cmd.last;
                    meter_next = cmd.meter;
                    neg_next   = sample[SAMPLE_W-1];
                    if (cmd.bypass)
                    begin
                        trim_next  = sample;
                        state_next = C_SQL;
                    end
                    else
                    begin
                        mul_load   = 1'b1;
                        state_next = C_TRIM;
                    end
                end
            end
            C_TRIM:
            begin
                if (mul_done)
                begin
                    trim_next  = trim_val;
                    state_next = C_SQL;
                end
            end
            C_SQL:
            begin
                mul_a = {1'b0, mm};
                mul_b = GAIN_W'(mm);
                if (meter_reg)
                begin
                    mul_load   = 1'b1;
                    state_next = C_SQ;
                end
                else
                begin
                    state_next = C_ACC;
                end
            end
            C_SQ:
            begin
                if (mul_done)
                begin
                    state_next = C_ACC;
                end
            end
            C_ACC:
            begin
                if (last_reg)
                begin
                    div_load      = 1'b1;
                    peak_out_next = peak_upd;
                    div_zero_next = (count == '0);
                    peak_acc_next = '0;
                    sum_next      = '0;
                    state_next    = C_DIV;
                end
                else
                begin
                    peak_acc_next = peak_upd;
                    sum_next      = sum_upd;
                    state_next    = C_DONE;
                end
            end
            C_DIV:
            begin
                if (div_done)
                begin
                    sqrt_load  = 1'b1;
                    state_next = C_SQRT;
                end
            end
            C_SQRT:
            begin
                if (sqrt_done)
                begin
                    rms_next   = div_zero_reg ? '0 : root_clip;
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (cmd.ack)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            peak_acc_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            peak_acc_reg <= peak_acc_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trim_reg     <= trim_next;
        peak_out_reg <= peak_out_next;
        rms_reg      <= rms_next;
        neg_reg      <= neg_next;
        last_reg     <= last_next;
        meter_reg    <= meter_next;
        div_zero_reg <= div_zero_next;
    end

    assign done    = (state_reg == C_DONE);
    assign trimmed = trim_reg;
    assign peak    = peak_out_reg;
    assign rms     = rms_reg;

endmodule

// ----- src/stereo_trim_peak_rms_meter.sv -----
// Each transaction runs the trim multiply unless the trim is bypassed, then the
// square unless past the block limit; block_end adds the divide and root. The
// 23-step serial multiplier, 60-step divider and 30-step root are not pipelined:
// a new transaction is accepted only after the previous result is registered.
// Reset: asynchronous, active low; clears accumulators, block count and output
// valid, and sets trim_gain to unity and right_present to one.
module stereo_trim_peak_rms_meter
    import stpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_ready,
    input  sample_in_t       src_data,
    output logic             res_valid,
    input  logic             res_ready,
    output meter_out_t       res_data,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_BUSY = 2'b10
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [GAIN_W-1:0] trim_gain_reg;
    logic              right_present_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              res_valid_reg, res_valid_next;
    meter_out_t        res_data_reg, res_data_next;
    logic              active_reg, rp_reg, last_reg;

    logic                       accept;
    logic                       load;
    logic                       slot_free;
    logic                       active_now;
    logic                       bypass;
    logic [GAIN_W-1:0]          gain_diff;
    chan_cmd_t                  cmd_l, cmd_r;
    logic                       done_l, done_r;
    logic signed [SAMPLE_W-1:0] trim_l, trim_r;
    logic [MAG_W-1:0]           peak_l, peak_r, rms_l, rms_r;

    assign src_ready  = (state_reg == T_IDLE);
    assign accept     = src_valid && src_ready;
    assign slot_free  = !res_valid_reg || res_ready;
    assign load       = (state_reg == T_BUSY) && done_l && done_r && slot_free;
    assign active_now = (count_reg < CNT_W'(MAX_BLOCK));
    assign gain_diff  = (trim_gain_reg >= UNITY) ? trim_gain_reg - UNITY
                                                 : UNITY - trim_gain_reg;
    assign bypass     = (gain_diff <= BYPASS_TOL);

    always_comb
    begin
        cmd_l.start  = accept;
        cmd_l.ack    = load;
        cmd_l.bypass = bypass;
        cmd_l.meter  = active_now;
        cmd_l.last   = src_data.block_end;
        cmd_r        = cmd_l;
        cmd_r.meter  = active_now && right_present_reg;
    end

    stpm_chan u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_l),
        .sample  (src_data.sample_left),
        .gain    (trim_gain_reg),
        .count   (count_reg),
        .done    (done_l),
        .trimmed (trim_l),
        .peak    (peak_l),
        .rms     (rms_l)
    );

    stpm_chan u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_r),
        .sample  (src_data.sample_right),
        .gain    (trim_gain_reg),
        .count   (count_reg),
        .done    (done_r),
        .trimmed (trim_r),
        .peak    (peak_r),
        .rms     (rms_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (active_now)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (load)
                begin
                    // Samples past the block limit come out as zero.
                    res_data_next = '0;
                    if (active_reg)
                    begin
                        res_data_next.trimmed_left  = trim_l;
                        res_data_next.trimmed_right = rp_reg ? trim_r : trim_l;
                    end
                    if (last_reg)
                    begin
                        res_data_next.meter_valid = 1'b1;
                        res_data_next.peak_left   = peak_l;
                        res_data_next.rms_left    = rms_l;
                        if (rp_reg)
                        begin
                            res_data_next.peak_right = peak_r;
                            res_data_next.rms_right  = rms_r;
                        end
                        count_next = '0;
                    end
                    res_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            count_reg         <= '0;
            res_valid_reg     <= 1'b0;
            trim_gain_reg     <= UNITY;
            right_present_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TRIM_GAIN:     trim_gain_reg     <= cfg_data[GAIN_W-1:0];
                    CFG_RIGHT_PRESENT: right_present_reg <= cfg_data[0];
                    default:           trim_gain_reg     <= trim_gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        if (accept)
        begin
            active_reg <= active_now;
            rp_reg     <= right_present_reg;
            last_reg   <= src_data.block_end;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef NO_ASSERTIONS
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && active_now |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("block count did not advance on a metered transaction");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load && last_reg |=> count_reg == '0)
        else $error("block count not cleared after block end");

    a_meter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_data_reg.meter_valid |->
            res_data_reg.peak_left == '0 && res_data_reg.peak_right == '0 &&
            res_data_reg.rms_left == '0 && res_data_reg.rms_right == '0)
        else $error("meter fields nonzero without meter_valid");

    a_right_absent: assert property (@(posedge clk) disable iff (!rst_n)
        load && !rp_reg |=>
            res_data_reg.trimmed_right == res_data_reg.trimmed_left &&
            res_data_reg.peak_right == '0 && res_data_reg.rms_right == '0)
        else $error("right channel output wrong while right input absent");
`endif

endmodule
